@@ rtl/core/adaptive_sliding_mode_step_macros.svh @@
// Assertion macros shared by the checker of the sliding-mode step block.
// No dependencies; the including module must supply clk and rst.
`ifndef ADAPTIVE_SLIDING_MODE_STEP_MACROS_SVH
`define ADAPTIVE_SLIDING_MODE_STEP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASMS_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define ASMS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/asms_pkg.sv @@
// Package of the sliding-mode step block: payload types, register indexes,
// sequencer states and reset constants. No dependencies.
`default_nettype none

package asms_pkg;

  localparam int VALUE_WIDTH_DEF   = 24;
  localparam int FRACTION_BITS_DEF = 16;

  // Register reset values
  localparam logic [22:0] SLOPE_RST    = 23'd52429;
  localparam logic [22:0] PHI_RST      = 23'd9830;
  localparam logic [16:0] FORGET_RST   = 17'd655;
  localparam logic [22:0] LIMIT_RST    = 23'd196608;
  localparam logic [22:0] START_RST    = 23'd6554;
  localparam logic [16:0] RATE_SM_RST  = 17'd45875;
  localparam logic [16:0] SURF_SM_RST  = 17'd52429;

  typedef enum logic [2:0] {
    REG_SLOPE      = 3'd0,
    REG_BOUNDARY   = 3'd1,
    REG_FORGET_B   = 3'd2,
    REG_FORGET_E   = 3'd3,
    REG_GAIN_LIMIT = 3'd4,
    REG_GAIN_START = 3'd5,
    REG_RATE_SM    = 3'd6,
    REG_SURF_SM    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [23:0] target_angle;
    logic signed [23:0] measured_angle;
    logic signed [23:0] raw_rate;
    logic        [12:0] time_step;
  } in_t;

  typedef struct packed {
    logic signed [17:0] drive;
    logic signed [23:0] surface_value;
    logic        [22:0] base_gain;
    logic        [22:0] error_gain;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RATE_NEW,
    S_RATE_OLD,
    S_RATE_SUM,
    S_SURF_OLD,
    S_SURF_NEW,
    S_SURF_SUM,
    S_EQUIV,
    S_KD0,
    S_KD1_PROD,
    S_KD1,
    S_GAIN0,
    S_GAIN1,
    S_RHO_PROD,
    S_RHO,
    S_SWITCH,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/adaptive_sliding_mode_step.sv @@
// Adaptive sliding-mode controller step with boundary layer, Q(W-F).F signed.
// One item at a time: a sequencer drives a shared multiplier (registered
// product) through sixteen steps while a restoring divider forms the boundary
// quotient when |s| lies within the layer; when it runs, the divider sets the
// pace at the default fraction bits, and the next item is taken once the
// sequencer is back in idle. The result sits in an output register, so a new
// item may start while it waits to be taken. Writing gain_start reloads both
// gains at once. Depends on asms_pkg, asms_mul and asms_div.
`default_nettype none

module adaptive_sliding_mode_step #(
  parameter int VALUE_WIDTH   = asms_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = asms_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire asms_pkg::in_t       in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output asms_pkg::out_t           out_data,
  input  wire logic                cfg_we,
  input  wire asms_pkg::reg_idx_t  cfg_index,
  input  wire logic [22:0]         cfg_data
);
  import asms_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int MW = (W > F + 1) ? W : F + 1;
  localparam int EW = ((W > 24) ? W : 24) + 2;
  localparam logic signed [EW-1:0] VMAX = {{(EW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [EW-1:0] VMIN = {{(EW - W + 1){1'b1}}, {(W - 1){1'b0}}};
  localparam logic signed [EW-1:0] ONE_E = EW'(1) << F;
  localparam logic signed [MW:0]   ONE_M = (MW + 1)'(1) << F;

  function automatic logic signed [W-1:0] sat(input logic signed [EW-1:0] x);
    if (x > VMAX) return VMAX[W-1:0];
    if (x < VMIN) return VMIN[W-1:0];
    return x[W-1:0];
  endfunction

  function automatic logic signed [EW-1:0] ext(input logic signed [W-1:0] v);
    return EW'(v);
  endfunction

  function automatic logic signed [MW:0] op(input logic signed [W-1:0] v);
    return (MW + 1)'(v);
  endfunction

  function automatic logic signed [MW:0] wgt(input logic [16:0] r);
    logic signed [EW-1:0] e;
    e = EW'(r);
    if (e > ONE_E) e = ONE_E;
    return e[MW:0];
  endfunction

  function automatic logic signed [W-1:0] abs_sat(input logic signed [W-1:0] v);
    return v[W-1] ? sat(-ext(v)) : v;
  endfunction

  // Clamp an adaptive gain to the range from zero to the limit
  function automatic logic signed [W-1:0] gclamp(input logic signed [W-1:0] g,
                                                 input logic signed [W-1:0] lim);
    if (g < 0) return '0;
    if (g > lim) return lim;
    return g;
  endfunction

  // Configuration registers
  logic [22:0] r_slope, r_phi, r_lim, r_start;
  logic [16:0] r_fb, r_fe, r_ar, r_as;

  // Sequencer and datapath registers
  state_t state, state_next;
  logic signed [W-1:0] tgt, meas, raw, err, abs_e, t1, fr, sr, fs, s, abs_s;
  logic signed [W-1:0] ueq, kd0, kd1, g0, g1, rho;
  logic [12:0] dt;
  logic s_big, s_neg;

  // Combinational helpers
  logic signed [W-1:0] slope_v, lim_v, phi_s, mul_res, usw, tot_w;
  logic [W-2:0] phi_v;
  logic [W-1:0] ms;
  logic [W+F-1:0] numer;
  logic signed [MW:0] mul_a, mul_b, bnd;
  logic mul_go, div_start, div_busy, out_free, in_acc;
  logic [F:0] quot;
  logic signed [EW-1:0] tot_e, ms_e;
  logic signed [EW-1:0] s_x, g0_x, g1_x;

  assign in_ready = state == S_IDLE;
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Register-derived operands
  always_comb begin
    slope_v = sat(EW'(r_slope));
    lim_v   = sat(EW'(r_lim));
    phi_s   = sat(EW'(r_phi));
    if (phi_s < W'(1)) phi_s = W'(1);
    phi_v   = phi_s[W-2:0];
  end

  // Boundary-layer numerator and saturated term
  always_comb begin
    ms_e  = s[W-1] ? -ext(s) : ext(s);
    ms    = ms_e[W-1:0];
    numer = {ms[W-2:0], {F{1'b0}}} + (W + F)'(phi_v >> 1);
    if (s_big) bnd = s_neg ? -ONE_M : ONE_M;
    else       bnd = s_neg ? -((MW + 1)'(quot)) : (MW + 1)'(quot);
  end

  // Final drive: equivalent plus switching term, clamped to plus or minus one
  always_comb begin
    usw   = sat(-ext(mul_res));
    tot_w = sat(ext(ueq) + ext(usw));
    tot_e = ext(tot_w);
    if (tot_e > ONE_E)  tot_e = ONE_E;
    if (tot_e < -ONE_E) tot_e = -ONE_E;
  end

  // Widen the reported state to the payload fields
  always_comb begin
    s_x  = ext(s);
    g0_x = ext(g0);
    g1_x = ext(g1);
  end

  asms_mul #(.W(W), .F(F), .MW(MW)) u_mul (
    .clk (clk),
    .go  (mul_go),
    .a   (mul_a),
    .b   (mul_b),
    .res (mul_res)
  );

  asms_div #(.W(W), .F(F)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_hi (numer[W+F-1:F+1]),
    .num_lo (numer[F:0]),
    .den    (phi_v),
    .busy   (div_busy),
    .quot   (quot)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and multiplier issue
  always_comb begin
    state_next = state;
    mul_go     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_RATE_NEW;
      S_RATE_NEW: begin
        mul_go = 1'b1; mul_a = wgt(r_ar); mul_b = op(raw);
        state_next = S_RATE_OLD;
      end
      S_RATE_OLD: begin
        mul_go = 1'b1; mul_a = ONE_M - wgt(r_ar); mul_b = op(fr);
        state_next = S_RATE_SUM;
      end
      S_RATE_SUM: begin
        mul_go = 1'b1; mul_a = op(slope_v); mul_b = op(err);
        state_next = S_SURF_OLD;
      end
      S_SURF_OLD: begin
        mul_go = 1'b1; mul_a = ONE_M - wgt(r_as); mul_b = op(fs);
        state_next = S_SURF_NEW;
      end
      S_SURF_NEW: begin
        mul_go = 1'b1; mul_a = wgt(r_as); mul_b = op(sr);
        state_next = S_SURF_SUM;
      end
      S_SURF_SUM: state_next = S_EQUIV;
      S_EQUIV: begin
        mul_go = 1'b1; mul_a = op(slope_v); mul_b = op(s);
        div_start = ms <= {1'b0, phi_v};
        state_next = S_KD0;
      end
      S_KD0: begin
        mul_go = 1'b1; mul_a = wgt(r_fb); mul_b = op(g0);
        state_next = S_KD1_PROD;
      end
      S_KD1_PROD: begin
        mul_go = 1'b1; mul_a = op(abs_s); mul_b = op(abs_e);
        state_next = S_KD1;
      end
      S_KD1: begin
        mul_go = 1'b1; mul_a = wgt(r_fe); mul_b = op(g1);
        state_next = S_GAIN0;
      end
      S_GAIN0: begin
        mul_go = 1'b1; mul_a = op(kd0); mul_b = (MW + 1)'(dt);
        state_next = S_GAIN1;
      end
      S_GAIN1: begin
        mul_go = 1'b1; mul_a = op(kd1); mul_b = (MW + 1)'(dt);
        state_next = S_RHO_PROD;
      end
      S_RHO_PROD: state_next = S_RHO;
      S_RHO: begin
        mul_go = 1'b1; mul_a = op(g1); mul_b = op(abs_e);
        state_next = S_SWITCH;
      end
      S_SWITCH: begin
        // hold until the quotient is ready
        if (!div_busy) begin
          mul_go = 1'b1; mul_a = op(sat(ext(g0) + ext(mul_res))); mul_b = bnd;
          state_next = S_DONE;
        end
      end
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Configuration writes; a gain_start write reloads both gains
  always_ff @(posedge clk) begin
    if (rst) begin
      r_slope <= SLOPE_RST;
      r_phi   <= PHI_RST;
      r_fb    <= FORGET_RST;
      r_fe    <= FORGET_RST;
      r_lim   <= LIMIT_RST;
      r_start <= START_RST;
      r_ar    <= RATE_SM_RST;
      r_as    <= SURF_SM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOPE:      r_slope <= cfg_data;
        REG_BOUNDARY:   r_phi   <= cfg_data;
        REG_FORGET_B:   r_fb    <= cfg_data[16:0];
        REG_FORGET_E:   r_fe    <= cfg_data[16:0];
        REG_GAIN_LIMIT: r_lim   <= cfg_data;
        REG_GAIN_START: r_start <= cfg_data;
        REG_RATE_SM:    r_ar    <= cfg_data[16:0];
        REG_SURF_SM:    r_as    <= cfg_data[16:0];
        default:        r_start <= r_start;
      endcase
    end
  end

  // Controller state: filters and adaptive gains
  always_ff @(posedge clk) begin
    if (rst) begin
      fr <= '0;
      fs <= '0;
      g0 <= sat(EW'(START_RST));
      g1 <= sat(EW'(START_RST));
    end else if (cfg_we && cfg_index == REG_GAIN_START) begin
      g0 <= sat(EW'(cfg_data));
      g1 <= sat(EW'(cfg_data));
    end else begin
      case (state)
        S_RATE_SUM: fr <= sat(ext(t1) + ext(mul_res));
        S_SURF_SUM: fs <= sat(ext(mul_res) + ext(t1));
        S_GAIN1:    g0 <= gclamp(sat(ext(g0) + ext(mul_res)), lim_v);
        S_RHO_PROD: g1 <= gclamp(sat(ext(g1) + ext(mul_res)), lim_v);
        default:    fr <= fr;
      endcase
    end
  end

  // Per-item working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          tgt  <= sat(EW'(in_data.target_angle));
          meas <= sat(EW'(in_data.measured_angle));
          raw  <= sat(EW'(in_data.raw_rate));
          dt   <= in_data.time_step;
        end
      end
      S_RATE_NEW: begin
        err   <= sat(ext(tgt) - ext(meas));
        abs_e <= abs_sat(sat(ext(tgt) - ext(meas)));
      end
      S_RATE_OLD: t1 <= mul_res;
      S_SURF_OLD: sr <= sat(-ext(fr) + ext(mul_res));
      S_SURF_NEW: t1 <= mul_res;
      S_SURF_SUM: s  <= sat(ext(mul_res) + ext(t1));
      S_EQUIV: begin
        abs_s <= abs_sat(s);
        s_big <= ms > {1'b0, phi_v};
        s_neg <= s[W-1];
      end
      S_KD0:      ueq <= sat(-ext(mul_res));
      S_KD1_PROD: kd0 <= sat(ext(abs_s) - ext(mul_res));
      S_KD1:      t1  <= mul_res;
      S_GAIN0:    kd1 <= sat(ext(t1) - ext(mul_res));
      S_SWITCH:   if (!div_busy) rho <= sat(ext(g0) + ext(mul_res));
      default:    t1 <= t1;
    endcase
  end

  // Output register: load when the step ends, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_data.drive         <= tot_e[17:0];
      out_data.surface_value <= s_x[23:0];
      out_data.base_gain     <= g0_x[22:0];
      out_data.error_gain    <= g1_x[22:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/asms_mul.sv @@
// Shared fixed-point multiplier: registered magnitude product, then
// round half away from zero, shift and saturate. Depends on nothing.
`default_nettype none

module asms_mul #(
  parameter int W  = 24,
  parameter int F  = 16,
  parameter int MW = 24
) (
  input  wire logic                clk,
  input  wire logic                go,
  input  wire logic signed [MW:0]  a,
  input  wire logic signed [MW:0]  b,
  output logic signed [W-1:0]      res
);

  localparam int PW = 2 * MW + 1;
  localparam logic [PW-1:0] VMAXU = {{(PW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic [PW-1:0] HALF  = PW'(1) << (F - 1);

  logic [MW-1:0]   ma, mb;
  logic [2*MW-1:0] prod;
  logic            neg;
  logic [PW-1:0]   rnd;
  logic signed [MW:0] na, nb;

  // Take magnitudes of both operands
  always_comb begin
    na = -a;
    nb = -b;
    ma = a[MW] ? na[MW-1:0] : a[MW-1:0];
    mb = b[MW] ? nb[MW-1:0] : b[MW-1:0];
  end

  // Hold the product until the next issue
  always_ff @(posedge clk) begin
    if (go) begin
      prod <= ma * mb;
      neg  <= a[MW] ^ b[MW];
    end
  end

  // Round, shift and saturate
  always_comb begin
    rnd = ({1'b0, prod} + HALF) >> F;
    if (neg) begin
      if (rnd > VMAXU + PW'(1)) res = {1'b1, {(W - 1){1'b0}}};
      else                      res = -(rnd[W-1:0]);
    end else begin
      if (rnd > VMAXU) res = {1'b0, {(W - 1){1'b1}}};
      else             res = rnd[W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/asms_div.sv @@
// Restoring divider for the boundary-layer quotient, one quotient bit a cycle.
// Expects num_hi < den so the quotient fits F+1 bits. Depends on nothing.
`default_nettype none

module asms_div #(
  parameter int W = 24,
  parameter int F = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-2:0] num_hi,
  input  wire logic [F:0]   num_lo,
  input  wire logic [W-2:0] den,
  output logic              busy,
  output logic [F:0]        quot
);

  localparam int CW = $clog2(F + 2);

  logic [W-1:0]  rem;
  logic [F:0]    low;
  logic [CW-1:0] cnt;
  logic [W-1:0]  trial;
  logic          fits;

  always_comb begin
    trial = {rem[W-2:0], low[F]};
    fits  = trial >= {1'b0, den};
  end

  // Control: count quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(F + 1);
    end else if (busy) begin
      cnt  <= cnt - CW'(1);
      busy <= cnt != CW'(1);
    end
  end

  // Datapath: shift in one numerator bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, num_hi};
      low  <= num_lo;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? trial - {1'b0, den} : trial;
      low  <= {low[F-1:0], 1'b0};
      quot <= {quot[F-1:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/asms_check.sv @@
// Port-level checker for the sliding-mode step block, bound to the top level.
// Depends on asms_pkg and adaptive_sliding_mode_step_macros.svh.
`default_nettype none

`include "adaptive_sliding_mode_step_macros.svh"

module asms_check #(
  parameter int F = asms_pkg::FRACTION_BITS_DEF
) (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire asms_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire asms_pkg::out_t out_data
);
  import asms_pkg::*;

  localparam logic signed [17:0] ONE_D = 18'(1) << F;

  logic in_txn;
  assign in_txn = in_valid && in_ready;

  // Drive stays within plus or minus one
  `ASMS_IMPLIES(a_drive_range, out_valid, (out_data.drive <= ONE_D) && (out_data.drive >= -ONE_D), "drive out of range")
  // Block is busy after taking a transaction
  `ASMS_NEXT(a_busy_after_in, in_txn, !in_ready, "ready after input transaction")
  // No result appears the cycle after an input transaction
  `ASMS_NEXT(a_no_early_out, in_txn && !out_valid, !out_valid, "result too early")
  // A stalled result holds
  `ASMS_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind adaptive_sliding_mode_step asms_check #(.F(FRACTION_BITS)) u_check (.*);

`default_nettype wire

@@ bench/adaptive_sliding_mode_step_tb.sv @@
// Self-checking bench for the adaptive sliding-mode step block: a behavioral
// predictor, a burst driver, a stalling monitor and phased register settings.
// Depends on asms_pkg and the adaptive_sliding_mode_step RTL.
`default_nettype none

module adaptive_sliding_mode_step_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import asms_pkg::*;

  localparam longint ONE = 64'sd65536;
  localparam longint VMAX = 64'sd8388607;
  localparam longint VMIN = -64'sd8388608;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  reg_idx_t cfg_index = REG_SLOPE;
  logic [22:0] cfg_data = '0;

  adaptive_sliding_mode_step dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor copy of registers and controller state
  longint ctl_reg [8];
  longint rate_lp, surf_lp, gain_b, gain_e;

  in_t  pending_items [$];
  out_t expected_steps [$];
  int   mismatches = 0;
  int   accepted = 0;
  bit   gen_done = 1'b0;

  function automatic longint sat(longint x);
    if (x > VMAX) return VMAX;
    if (x < VMIN) return VMIN;
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint ma, mb, p;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = (ma * mb + 64'sd32768) >>> 16;
    return sat(((a < 0) != (b < 0)) ? -p : p);
  endfunction

  function automatic longint wt(int idx);
    return ctl_reg[idx] > ONE ? ONE : ctl_reg[idx];
  endfunction

  function automatic longint gclamp(longint g, longint lim);
    if (g < 0) g = 0;
    if (g > lim) g = lim;
    return g;
  endfunction

  function automatic void reset_model();
    ctl_reg[REG_SLOPE] = SLOPE_RST;       ctl_reg[REG_BOUNDARY] = PHI_RST;
    ctl_reg[REG_FORGET_B] = FORGET_RST;   ctl_reg[REG_FORGET_E] = FORGET_RST;
    ctl_reg[REG_GAIN_LIMIT] = LIMIT_RST;  ctl_reg[REG_GAIN_START] = START_RST;
    ctl_reg[REG_RATE_SM] = RATE_SM_RST;   ctl_reg[REG_SURF_SM] = SURF_SM_RST;
    rate_lp = 0; surf_lp = 0;
    gain_b = START_RST; gain_e = START_RST;
  endfunction

  // Compute the expected result of one controller step and advance state
  function automatic out_t predict_step(in_t it);
    longint err, sraw, s, abs_s, abs_e, kd0, kd1, rho, ueq, usw, tot, phi, lim, slope;
    longint ar, as, ms, bq;
    out_t r;
    slope = ctl_reg[REG_SLOPE];
    phi = ctl_reg[REG_BOUNDARY] < 1 ? 1 : ctl_reg[REG_BOUNDARY];
    lim = ctl_reg[REG_GAIN_LIMIT];
    ar = wt(REG_RATE_SM);
    as = wt(REG_SURF_SM);
    rate_lp = sat(qmul(ar, longint'(it.raw_rate)) + qmul(ONE - ar, rate_lp));
    err = sat(longint'(it.target_angle) - longint'(it.measured_angle));
    sraw = sat(-rate_lp + qmul(slope, err));
    s = sat(qmul(as, sraw) + qmul(ONE - as, surf_lp));
    surf_lp = s;
    ueq = sat(-qmul(slope, s));
    abs_s = sat(s < 0 ? -s : s);
    abs_e = sat(err < 0 ? -err : err);
    kd0 = sat(abs_s - qmul(wt(REG_FORGET_B), gain_b));
    kd1 = sat(qmul(abs_s, abs_e) - qmul(wt(REG_FORGET_E), gain_e));
    gain_b = gclamp(sat(gain_b + qmul(kd0, longint'(it.time_step))), lim);
    gain_e = gclamp(sat(gain_e + qmul(kd1, longint'(it.time_step))), lim);
    rho = sat(gain_b + qmul(gain_e, abs_e));
    ms = s < 0 ? -s : s;
    if (ms > phi) bq = s > 0 ? ONE : -ONE;
    else begin
      bq = (ms * ONE + (phi >>> 1)) / phi;
      if (s < 0) bq = -bq;
    end
    usw = sat(-qmul(rho, bq));
    tot = sat(ueq + usw);
    if (tot > ONE) tot = ONE;
    if (tot < -ONE) tot = -ONE;
    r.drive = tot[17:0];
    r.surface_value = s[23:0];
    r.base_gain = gain_b[22:0];
    r.error_gain = gain_e[22:0];
    return r;
  endfunction

  // Driver: bursts with random gaps, hold valid until accepted
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_steps.push_back(predict_step(in_data));
        accepted <= accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end else burst_left <= burst_left - 1;
        end else in_valid <= 1'b0;
      end
    end
  end

  // Monitor: stall pattern and field-by-field compare
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst) begin
      stall_phase <= (stall_phase + 1) % 97;
      out_ready <= (stall_phase < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
      if (out_valid && out_ready) begin
        if (expected_steps.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %p", out_data);
        end else begin
          out_t e;
          e = expected_steps.pop_front();
          if (e.drive !== out_data.drive || e.surface_value !== out_data.surface_value ||
              e.base_gain !== out_data.base_gain || e.error_gain !== out_data.error_gain)
          begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected %p actual %p", e, out_data);
          end
        end
      end
    end
  end

  function automatic in_t rand_item(bit wild);
    in_t it;
    if (wild) begin
      it.target_angle = 24'($urandom);
      it.measured_angle = 24'($urandom);
      it.raw_rate = 24'($urandom);
    end else begin
      it.target_angle = 24'(int'($urandom_range(0, 400000)) - 200000);
      it.measured_angle = 24'(int'($urandom_range(0, 400000)) - 200000);
      it.raw_rate = 24'(int'($urandom_range(0, 600000)) - 300000);
    end
    it.time_step = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(66, 6554));
    return it;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_steps.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Write one register, then drop the enable before returning so back-to-back writes never
  // update the enable twice at the same edge
  task automatic write_reg(reg_idx_t idx, longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[22:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    ctl_reg[idx] = (idx == REG_FORGET_B || idx == REG_FORGET_E || idx == REG_RATE_SM ||
                    idx == REG_SURF_SM) ? (val & 64'h1FFFF) : (val & 64'h7FFFFF);
    if (idx == REG_GAIN_START) begin
      gain_b = ctl_reg[idx];
      gain_e = ctl_reg[idx];
    end
    @(posedge clk);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) pending_items.push_back(rand_item($urandom_range(0, 4) == 0));
    wait_idle();
  endtask

  initial begin
    in_t d;
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, zero and odd time steps, wide sign swings
    for (int k = 0; k < 20; k++) begin
      d.target_angle = (k % 2) ? 24'sh7FFFFF : 24'sh800000;
      d.measured_angle = (k % 3 == 0) ? 24'sh800000 : ((k % 3 == 1) ? 24'sh7FFFFF : 24'sh0);
      d.raw_rate = (k % 4 < 2) ? 24'sh7FFFFF : 24'sh800000;
      d.time_step = (k % 5 == 0) ? 13'd0 : ((k % 5 == 1) ? 13'h1FFF : 13'd66);
      if (k >= 15) d = '0;
      pending_items.push_back(d);
    end
    wait_idle();
    run_random(400);

    // Extremes: weights above one, zero boundary, start above limit
    write_reg(REG_SLOPE, 64'h7FFFFF);
    write_reg(REG_BOUNDARY, 0);
    write_reg(REG_FORGET_B, 64'h1FFFF);
    write_reg(REG_FORGET_E, 0);
    write_reg(REG_GAIN_LIMIT, 1000);
    write_reg(REG_GAIN_START, 64'h7FFFFF);
    write_reg(REG_RATE_SM, 64'h1FFFF);
    write_reg(REG_SURF_SM, 0);
    run_random(300);

    write_reg(REG_SLOPE, 0);
    write_reg(REG_BOUNDARY, 64'h7FFFFF);
    write_reg(REG_FORGET_B, 0);
    write_reg(REG_FORGET_E, 65536);
    write_reg(REG_GAIN_LIMIT, 64'h7FFFFF);
    write_reg(REG_GAIN_START, 0);
    write_reg(REG_RATE_SM, 0);
    write_reg(REG_SURF_SM, 65536);
    run_random(300);

    write_reg(REG_SLOPE, 100000);
    write_reg(REG_BOUNDARY, 1);
    write_reg(REG_FORGET_B, 3000);
    write_reg(REG_FORGET_E, 64'h10000 | 64'h0AAAA);
    write_reg(REG_GAIN_LIMIT, 0);
    write_reg(REG_GAIN_START, 64'h555555);
    write_reg(REG_RATE_SM, 30000);
    write_reg(REG_SURF_SM, 64'h1FFFF);
    run_random(330);

    if (mismatches == 0 && expected_steps.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end
endmodule

`default_nettype wire
